### rtl/core/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared sizes, register codes and stage structs for the int8 max pool block.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int MAX_CHANNELS = 256;
  localparam int MAX_WINDOW   = 64;

  localparam int DATA_W      = 8;
  localparam int CHAN_W      = $clog2(MAX_CHANNELS);
  localparam int WIN_W       = $clog2(MAX_WINDOW);
  localparam int CH_CNT_W    = 9;
  localparam int WIN_SIZE_W  = 7;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 9;

  // result queue between the update stage and the output port
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHANNEL_COUNT = 4'd0,
    REG_WINDOW_SIZE   = 4'd1,
    REG_OUT_MIN       = 4'd2,
    REG_OUT_MAX       = 4'd3
  } cfg_reg_t;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [CHAN_W-1:0]        chan_last;
    logic [WIN_W-1:0]         win_last;
    logic signed [DATA_W-1:0] out_min;
    logic signed [DATA_W-1:0] out_max;
  } cfg_t;

  // one accepted sample with its position flags
  typedef struct packed {
    logic [CHAN_W-1:0]        chan;
    logic                     first;
    logic                     last_win;
    logic                     last_ch;
    logic signed [DATA_W-1:0] sample;
  } issue_t;

  // one result word
  typedef struct packed {
    logic signed [DATA_W-1:0] pooled;
    logic [CHAN_W-1:0]        channel_index;
    logic                     last_of_pixel;
  } result_t;

endpackage

### rtl/core/int8_max_pool_clamp.sv
// ----------------------------------------------------------------------------
// int8_max_pool_clamp
// Per-channel max pooling of signed 8-bit samples with a clamp on the result.
// ----------------------------------------------------------------------------
//   channel  handshake                   payload
//   sample   sample_valid / sample_stall  sample
//   result   result_valid / result_stall  pooled, channel_index, last_of_pixel
//   config   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One sample per cycle sustained while sample_stall is low. A sample reads its
// channel maximum from the RAM in the cycle it is accepted and writes it back in
// the next cycle; a result enters the output queue in that same cycle.
// Reset is synchronous; the maximum RAM is not cleared and needs no sweep.
// sample_stall comes from reset and registers only: it rises when the
// three-entry result queue plus the word in the update stage could fill it.
// ----------------------------------------------------------------------------
module int8_max_pool_clamp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic signed [mpc_pkg::DATA_W-1:0] sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [mpc_pkg::DATA_W-1:0] pooled,
  output logic [mpc_pkg::CHAN_W-1:0]       channel_index,
  output logic                             last_of_pixel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mpc_pkg::*;

  cfg_t                  cfg;
  logic                  accept;
  logic                  rd_en;
  logic [CHAN_W-1:0]     rd_addr;
  logic [DATA_W-1:0]     rd_data;
  logic                  s1_valid;
  issue_t                s1;
  logic                  wr_en;
  logic [CHAN_W-1:0]     wr_addr;
  logic [DATA_W-1:0]     wr_data;
  logic                  res_valid;
  result_t               res;
  result_t               head_data;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic                  pop;

  assign cfg_ready = 1'b1;

  // stall while the queue could not take every word in flight
  assign sample_stall = rst ||
    ((OUTQ_CNT_W + 1)'(q_count) + (OUTQ_CNT_W + 1)'(s1_valid)
      >= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
  assign accept = sample_valid && !sample_stall;
  assign pop    = result_valid && !result_stall;

  mpc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mpc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .sample   (sample),
    .cfg      (cfg),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  mpc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_CHANNELS)
  ) u_max_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mpc_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rd_data   (rd_data),
    .cfg       (cfg),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res       (res)
  );

  mpc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .pop        (pop),
    .head_valid (result_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  assign pooled        = head_data.pooled;
  assign channel_index = head_data.channel_index;
  assign last_of_pixel = head_data.last_of_pixel;

endmodule

### rtl/core/mpc_ram.sv
// ----------------------------------------------------------------------------
// mpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/mpc_cfg.sv
// ----------------------------------------------------------------------------
// mpc_cfg
// Configuration registers and their saturated effective limits.
// ----------------------------------------------------------------------------
module mpc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [mpc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [mpc_pkg::CFG_DATA_W-1:0]  wr_data,
  output mpc_pkg::cfg_t                  cfg
);
  import mpc_pkg::*;

  logic [CH_CNT_W-1:0]   channel_count;
  logic [WIN_SIZE_W-1:0] window_size;
  logic signed [DATA_W-1:0] out_min;
  logic signed [DATA_W-1:0] out_max;

  // write the addressed register, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CH_CNT_W'(1);
      window_size   <= WIN_SIZE_W'(1);
      out_min       <= -8'sd128;
      out_max       <= 8'sd127;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_CHANNEL_COUNT: channel_count <= wr_data[CH_CNT_W-1:0];
        REG_WINDOW_SIZE:   window_size   <= wr_data[WIN_SIZE_W-1:0];
        REG_OUT_MIN:       out_min       <= signed'(wr_data[DATA_W-1:0]);
        REG_OUT_MAX:       out_max       <= signed'(wr_data[DATA_W-1:0]);
        default: ;
      endcase
    end
  end

  // saturate counts: zero acts as one, oversize acts as the maximum
  always_comb begin
    priority if (channel_count == '0) begin
      cfg.chan_last = '0;
    end else if (channel_count > CH_CNT_W'(MAX_CHANNELS)) begin
      cfg.chan_last = CHAN_W'(MAX_CHANNELS - 1);
    end else begin
      cfg.chan_last = CHAN_W'(channel_count - CH_CNT_W'(1));
    end

    priority if (window_size == '0) begin
      cfg.win_last = '0;
    end else if (window_size > WIN_SIZE_W'(MAX_WINDOW)) begin
      cfg.win_last = WIN_W'(MAX_WINDOW - 1);
    end else begin
      cfg.win_last = WIN_W'(window_size - WIN_SIZE_W'(1));
    end

    cfg.out_min = out_min;
    cfg.out_max = out_max;
  end

endmodule

### rtl/core/mpc_seq.sv
// ----------------------------------------------------------------------------
// mpc_seq
// Channel and window position counters; issues the maximum read per sample.
// ----------------------------------------------------------------------------
module mpc_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic signed [mpc_pkg::DATA_W-1:0] sample,
  input  mpc_pkg::cfg_t                  cfg,
  output logic                           rd_en,
  output logic [mpc_pkg::CHAN_W-1:0]     rd_addr,
  output logic                           s1_valid,
  output mpc_pkg::issue_t                s1
);
  import mpc_pkg::*;

  logic [CHAN_W-1:0] channel_pos;
  logic [WIN_W-1:0]  window_pos;
  logic              last_ch;
  logic              last_win;

  // a position at or past the limit is the last one
  assign last_ch  = (channel_pos >= cfg.chan_last);
  assign last_win = (window_pos >= cfg.win_last);

  assign rd_en   = accept;
  assign rd_addr = channel_pos;

  // advance the counters on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_pos <= '0;
      window_pos  <= '0;
    end else if (accept) begin
      if (last_ch) begin
        channel_pos <= '0;
        window_pos  <= last_win ? '0 : window_pos + WIN_W'(1);
      end else begin
        channel_pos <= channel_pos + CHAN_W'(1);
      end
    end
  end

  // input register of the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.chan     <= channel_pos;
      s1.first    <= (window_pos == '0);
      s1.last_win <= last_win;
      s1.last_ch  <= last_ch;
      s1.sample   <= sample;
    end
  end

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_ch && last_win |=> channel_pos == '0 && window_pos == '0)
    else $error("counters did not wrap at end of pixel");

endmodule

### rtl/core/mpc_fold.sv
// ----------------------------------------------------------------------------
// mpc_fold
// Update stage: fold the sample into the channel maximum, write it back and
// clamp it on the last window element.
// ----------------------------------------------------------------------------
module mpc_fold (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s1_valid,
  input  mpc_pkg::issue_t                s1,
  input  logic [mpc_pkg::DATA_W-1:0]     rd_data,
  input  mpc_pkg::cfg_t                  cfg,
  output logic                           wr_en,
  output logic [mpc_pkg::CHAN_W-1:0]     wr_addr,
  output logic [mpc_pkg::DATA_W-1:0]     wr_data,
  output logic                           res_valid,
  output mpc_pkg::result_t               res
);
  import mpc_pkg::*;

  logic                     fwd_valid;
  logic [CHAN_W-1:0]        fwd_chan;
  logic signed [DATA_W-1:0] fwd_max;
  logic signed [DATA_W-1:0] prior;
  logic signed [DATA_W-1:0] merged;
  logic signed [DATA_W-1:0] lo_clamped;

  // bypass the write that landed in the same cycle as this word's read
  assign prior = (fwd_valid && fwd_chan == s1.chan) ? fwd_max : signed'(rd_data);

  // first window element overwrites, later ones keep the larger
  assign merged = (s1.first || s1.sample > prior) ? s1.sample : prior;

  // lower bound first, then upper bound
  assign lo_clamped = (merged < cfg.out_min) ? cfg.out_min : merged;

  assign wr_en   = s1_valid;
  assign wr_addr = s1.chan;
  assign wr_data = merged;

  assign res_valid         = s1_valid && s1.last_win;
  assign res.pooled        = (lo_clamped > cfg.out_max) ? cfg.out_max : lo_clamped;
  assign res.channel_index = s1.chan;
  assign res.last_of_pixel = s1.last_ch;

  // hold the last write for the bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_chan <= s1.chan;
      fwd_max  <= merged;
    end
  end

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    res_valid && cfg.out_min <= cfg.out_max |->
      res.pooled >= cfg.out_min && res.pooled <= cfg.out_max)
    else $error("pooled value outside clamp bounds");

endmodule

### rtl/core/mpc_outq.sv
// ----------------------------------------------------------------------------
// mpc_outq
// Small result queue that decouples the output stall from the pipeline.
// ----------------------------------------------------------------------------
module mpc_outq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  mpc_pkg::result_t               push_data,
  input  logic                           pop,
  output logic                           head_valid,
  output mpc_pkg::result_t               head_data,
  output logic [mpc_pkg::OUTQ_CNT_W-1:0] count
);
  import mpc_pkg::*;

  result_t               entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] head;
  logic [OUTQ_PTR_W-1:0] tail;

  function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
    return (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + OUTQ_PTR_W'(1);
  endfunction

  assign head_valid = (count != '0);
  assign head_data  = entries[head];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      priority if (push && !pop) begin
        count <= count + OUTQ_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OUTQ_CNT_W'(1);
      end else begin
        count <= count;
      end
    end
  end

  // store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("result queue underflow");

endmodule

### sim/int8_max_pool_clamp_tb.sv
// ----------------------------------------------------------------------------
// int8_max_pool_clamp_tb
// Self-checking bench for the int8 max pool block. A behavioral mirror of the
// per-channel running maximum, the position counters and the clamp predicts
// every result word. A checker compares each word against the oldest
// prediction. Directed cases cover extreme samples, clamping, inverted and
// zero settings, mid-pixel writes and back-pressure. Random phases follow,
// each with its own mix of sender and receiver idling.
// ----------------------------------------------------------------------------
module int8_max_pool_clamp_tb;
  import mpc_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;

  // index that maps to no register; writes to it must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'hF;

  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 8'sd127;
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = -8'sd128;

  typedef enum int {MIX_FULL, MIX_NARROW, MIX_EXTREME} sample_mix_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [DATA_W-1:0]   sample = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [DATA_W-1:0]   pooled;
  logic [CHAN_W-1:0]          channel_index;
  logic                       last_of_pixel;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // mirror of the block: running maxima, positions and registers
  logic signed [DATA_W-1:0]   chan_max [MAX_CHANNELS];
  int                         chan_pos = 0;
  int                         win_pos = 0;
  logic [CH_CNT_W-1:0]        m_chan_count = 9'd1;
  logic [WIN_SIZE_W-1:0]      m_win_size = 7'd1;
  logic signed [DATA_W-1:0]   m_out_min = -8'sd128;
  logic signed [DATA_W-1:0]   m_out_max = 8'sd127;
  result_t                    pooled_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int n_errors = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_writes = 0;

  int8_max_pool_clamp i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pooled       (pooled),
    .channel_index(channel_index),
    .last_of_pixel(last_of_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // drive receiver stall: random idling, or a long hold when requested
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pooled_q.size() == 0) begin
        $error("result word with no prediction: pooled %0d channel %0d",
               pooled, channel_index);
        n_errors++;
      end else begin
        want = pooled_q.pop_front();
        n_results++;
        if (pooled !== want.pooled) begin
          $error("pooled: expected %0d, got %0d", want.pooled, pooled);
          n_errors++;
        end
        if (channel_index !== want.channel_index) begin
          $error("channel_index: expected %0d, got %0d", want.channel_index,
                 channel_index);
          n_errors++;
        end
        if (last_of_pixel !== want.last_of_pixel) begin
          $error("last_of_pixel: expected %0d, got %0d", want.last_of_pixel,
                 last_of_pixel);
          n_errors++;
        end
      end
    end
  end

  function automatic int eff_channels();
    int c;
    c = m_chan_count;
    if (c == 0) c = 1;
    if (c > MAX_CHANNELS) c = MAX_CHANNELS;
    return c;
  endfunction

  function automatic int eff_window();
    int w;
    w = m_win_size;
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    return w;
  endfunction

  // fold one sample into the mirror and queue the result it causes
  task automatic predict_pool(input logic signed [DATA_W-1:0] value);
    int nch;
    int nwin;
    int c;
    bit last_ch;
    bit last_win;
    logic signed [DATA_W-1:0] v;
    result_t r;
    nch = eff_channels();
    nwin = eff_window();
    c = chan_pos;
    if (c >= MAX_CHANNELS) c = MAX_CHANNELS - 1;
    if (win_pos == 0 || value > chan_max[c]) chan_max[c] = value;
    last_ch = (c + 1 >= nch);
    last_win = (win_pos + 1 >= nwin);
    if (last_win) begin
      // lower bound first, then upper: inverted bounds give out_max
      v = chan_max[c];
      if (v < m_out_min) v = m_out_min;
      if (v > m_out_max) v = m_out_max;
      r.pooled = v;
      r.channel_index = CHAN_W'(c);
      r.last_of_pixel = last_ch;
      pooled_q.push_back(r);
    end
    if (last_ch) begin
      chan_pos = 0;
      win_pos = last_win ? 0 : win_pos + 1;
    end else begin
      chan_pos = c + 1;
    end
  endtask

  // offer one sample word, idling first at random, and hold until accepted
  task automatic send_sample(input logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (sample_stall !== 1'b0);
    predict_pool(value);
    n_samples++;
  endtask

  // drop valid, drain all predictions, then let in-flight samples settle
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write one register word and mirror it
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_writes++;
    case (idx)
      REG_CHANNEL_COUNT: m_chan_count = data[CH_CNT_W-1:0];
      REG_WINDOW_SIZE:   m_win_size = data[WIN_SIZE_W-1:0];
      REG_OUT_MIN:       m_out_min = data[DATA_W-1:0];
      REG_OUT_MAX:       m_out_max = data[DATA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input int ch, input int win,
                           input logic signed [DATA_W-1:0] lo,
                           input logic signed [DATA_W-1:0] hi);
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(ch));
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win));
    write_reg(REG_OUT_MIN, {1'b0, lo});
    write_reg(REG_OUT_MAX, {1'b0, hi});
  endtask

  function automatic logic signed [DATA_W-1:0] random_sample(input sample_mix_t mix);
    int v;
    case (mix)
      MIX_NARROW: begin
        v = int'($urandom_range(0, 7)) - 4;
        return v[DATA_W-1:0];
      end
      MIX_EXTREME: begin
        case ($urandom_range(2))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          default: return DATA_W'($urandom);
        endcase
      end
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // pick new settings; never raise the channel count past the first window
  task automatic pick_settings();
    int cur_ch;
    int ch;
    int roll;
    int lo;
    int hi;
    logic [CFG_DATA_W-1:0] d;
    cur_ch = eff_channels();
    if ($urandom_range(1)) begin
      roll = $urandom_range(99);
      if (roll < 70)      d = CFG_DATA_W'($urandom_range(1, 8));
      else if (roll < 80) d = '0;
      else if (roll < 94) d = CFG_DATA_W'($urandom_range(9, 40));
      else if (roll < 97) d = CFG_DATA_W'(MAX_CHANNELS);
      else                d = CFG_DATA_W'($urandom_range(MAX_CHANNELS + 1, 511));
      ch = (d == 0) ? 1 : ((d > MAX_CHANNELS) ? MAX_CHANNELS : int'(d));
      if (win_pos == 0 || ch <= cur_ch) write_reg(REG_CHANNEL_COUNT, d);
    end
    // keep pixels short: long windows only with few channels
    if (eff_channels() > 8) begin
      d = CFG_DATA_W'($urandom_range(0, 6));
      d[CFG_DATA_W-1:WIN_SIZE_W] = 2'($urandom);
      write_reg(REG_WINDOW_SIZE, d);
    end else if ($urandom_range(1)) begin
      roll = $urandom_range(99);
      if (roll < 70)      d = CFG_DATA_W'($urandom_range(1, 6));
      else if (roll < 80) d = '0;
      else if (roll < 92) d = CFG_DATA_W'($urandom_range(7, 20));
      else if (roll < 96) d = CFG_DATA_W'(MAX_WINDOW);
      else                d = CFG_DATA_W'($urandom_range(MAX_WINDOW + 1, 127));
      d[CFG_DATA_W-1:WIN_SIZE_W] = 2'($urandom);
      write_reg(REG_WINDOW_SIZE, d);
    end
    if ($urandom_range(1)) begin
      roll = $urandom_range(99);
      lo = int'($urandom_range(0, 255)) - 128;
      hi = int'($urandom_range(0, 255)) - 128;
      if (roll < 50) begin
        lo = -128;
        hi = 127;
      end else if (roll < 85 && lo > hi) begin
        roll = lo;
        lo = hi;
        hi = roll;
      end
      write_reg(REG_OUT_MIN, {1'($urandom), lo[DATA_W-1:0]});
      write_reg(REG_OUT_MAX, {1'($urandom), hi[DATA_W-1:0]});
    end
  endtask

  // reset settings: one channel, window of one, no clamping
  task automatic test_reset_defaults();
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(8'sd0);
    send_sample(-8'sd1);
  endtask

  // running maximum over the window, including ties and the extremes
  task automatic test_window_max();
    wait_idle();
    set_shape(3, 3, SAMPLE_MIN, SAMPLE_MAX);
    send_sample(SAMPLE_MIN); send_sample(SAMPLE_MAX); send_sample(8'sd5);
    send_sample(SAMPLE_MIN); send_sample(SAMPLE_MIN); send_sample(8'sd5);
    send_sample(-8'sd127);   send_sample(8'sd0);      send_sample(8'sd5);
  endtask

  // clamp from both sides, then inverted bounds and an ignored index
  task automatic test_clamp();
    wait_idle();
    set_shape(2, 2, -8'sd10, 8'sd20);
    send_sample(-8'sd100); send_sample(8'sd100);
    send_sample(-8'sd50);  send_sample(8'sd15);
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 9'd1);
    write_reg(REG_OUT_MIN, 9'd50);
    write_reg(REG_OUT_MAX, {1'b1, -8'sd50});
    write_reg(REG_UNUSED, '1);
    send_sample(8'sd0);
    send_sample(SAMPLE_MAX);
  endtask

  // zero channel count and zero window both act as one
  task automatic test_zero_sizes();
    wait_idle();
    set_shape(0, 0, SAMPLE_MIN, SAMPLE_MAX);
    send_sample(8'sd3);
    send_sample(-8'sd3);
  endtask

  // shrink the window, then the channel count, in the middle of a pixel
  task automatic test_mid_pixel_config();
    wait_idle();
    set_shape(4, 4, SAMPLE_MIN, SAMPLE_MAX);
    repeat (6) send_sample(random_sample(MIX_FULL));
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 9'd2);
    repeat (2) send_sample(random_sample(MIX_FULL));
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 9'd3);
    repeat (2) send_sample(random_sample(MIX_FULL));
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 9'd1);
    repeat (3) send_sample(random_sample(MIX_FULL));
  endtask

  // largest channel count (saturated) and largest window (exact and saturated)
  task automatic test_size_extremes();
    wait_idle();
    set_shape(511, 1, SAMPLE_MIN, SAMPLE_MAX);
    repeat (MAX_CHANNELS) send_sample(random_sample(MIX_FULL));
    wait_idle();
    set_shape(1, MAX_WINDOW, -8'sd64, 8'sd63);
    repeat (MAX_WINDOW) send_sample(random_sample(MIX_EXTREME));
    wait_idle();
    set_shape(2, 127, SAMPLE_MIN, SAMPLE_MAX);
    repeat (2 * MAX_WINDOW) send_sample(random_sample(MIX_FULL));
  endtask

  // hold the receiver off so the result queue fills and the input stalls
  task automatic test_backpressure();
    wait_idle();
    set_shape(1, 1, SAMPLE_MIN, SAMPLE_MAX);
    send_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (40) send_sample(random_sample(MIX_FULL));
  endtask

  // random settings, whole and partial pixels, with the given idling mix
  task automatic test_random(input int n_items, input int s_pct, input int r_pct);
    int target;
    int per_pixel;
    int n_send;
    sample_mix_t mix;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = n_samples + n_items;
    while (n_samples < target) begin
      wait_idle();
      pick_settings();
      per_pixel = eff_channels() * eff_window();
      n_send = (per_pixel > 64) ? per_pixel : per_pixel * int'($urandom_range(1, 4));
      if ($urandom_range(99) < 20) n_send = $urandom_range(1, n_send);
      // stay within this phase's share of words
      if (n_send > target - n_samples) n_send = target - n_samples;
      mix = sample_mix_t'($urandom_range(2));
      repeat (n_send) send_sample(random_sample(mix));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 70;
    test_reset_defaults();
    test_window_max();
    test_clamp();
    test_zero_sizes();
    test_mid_pixel_config();
    test_size_extremes();
    test_backpressure();

    test_random(76, 12, 70);
    test_random(76, 70, 12);
    test_random(76, 0, 0);

    // drain and let the pipeline settle
    sample_valid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pooled_q.size() != 0) begin
      $error("%0d predicted result words never arrived", pooled_q.size());
      n_errors++;
    end

    $display("Run covered %0d sample words, %0d checked result words, %0d register writes",
             n_samples, n_results, n_writes);
    $display("across clamp, window, channel and back-pressure settings.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
